>>> rtl/sha1mh_pkg.sv
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Shared types and constants for the SHA-1 message hasher: word type, initial
// hash words, datapath operations and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_DIGEST = 5;

    // Initial hash words
    localparam t_word IV [NUM_DIGEST] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    // Round constants
    localparam t_word K_CH  = 32'h5A82_7999;
    localparam t_word K_P1  = 32'h6ED9_EBA1;
    localparam t_word K_MAJ = 32'h8F1B_BCDC;
    localparam t_word K_P2  = 32'hCA62_C1D6;

    // Pad byte 0x80 in the leading byte position
    localparam t_word PAD_WORD = 32'h8000_0000;

    // Position of the final digest word
    localparam logic [2:0] LAST_IDX = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ABSORB,
        OP_PAD,
        OP_ZERO,
        OP_LEN_HI,
        OP_LEN_LO,
        OP_ROUND,
        OP_ADD,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic blk_full;    // this insertion completes the 16th buffer word
        logic acc_empty;   // no partial word held
        logic at_len;      // 14 words buffered: length words go next
        logic round_done;  // final round of the compression
    } t_stat;

endpackage

>>> rtl/sha1mh_if.sv
// ----------------------------------------------------------------------------
// sha1mh_if
// Valid/ready channels of the SHA-1 message hasher: message words in,
// digest words out.
// ----------------------------------------------------------------------------
interface sha1mh_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last;

    modport source (output valid, output data_word, output bytes_valid, output last,
                    input ready);
    modport sink   (input valid, input data_word, input bytes_valid, input last,
                    output ready);
endinterface

interface sha1mh_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;

    modport source (output valid, output digest_word, output word_index, output digest_end,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input digest_end,
                    output ready);
endinterface

>>> rtl/sha1mh_datapath.sv
// ----------------------------------------------------------------------------
// sha1mh_datapath
// Byte packer, 16-word block buffer and schedule window, single round unit,
// chaining words and bit-length counter.
// ----------------------------------------------------------------------------
module sha1mh_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1mh_pkg::t_cmd   i_cmd,
    input  logic [31:0]        i_data_word,
    input  logic [2:0]         i_bytes_valid,
    output sha1mh_pkg::t_stat  o_stat,
    output logic [31:0]        o_digest_word
);

    sha1mh_pkg::t_word r_buf   [16];
    sha1mh_pkg::t_word r_chain [sha1mh_pkg::NUM_DIGEST];
    sha1mh_pkg::t_word r_work  [sha1mh_pkg::NUM_DIGEST];
    logic [31:0] r_acc;
    logic [1:0]  r_acc_cnt;
    logic [3:0]  r_wcnt;
    logic [63:0] r_len;
    logic [6:0]  r_round;

    logic [31:0] ins_data;
    logic [2:0]  ins_n;
    logic [31:0] ins_mask;
    logic [31:0] acc_keep;
    logic [63:0] cat;
    logic [2:0]  total;
    logic        push;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] sched;
    logic [31:0] xa, xb, xc, xd, xe;

    // Select the bytes to insert
    always_comb begin
        ins_data = 32'h0;
        ins_n    = 3'd0;
        case (i_cmd.op)
            sha1mh_pkg::OP_ABSORB: begin
                ins_data = i_data_word;
                ins_n    = (i_bytes_valid > 3'd4) ? 3'd4 : i_bytes_valid;
            end
            sha1mh_pkg::OP_PAD: begin
                ins_data = sha1mh_pkg::PAD_WORD;
                ins_n    = 3'd1;
            end
            sha1mh_pkg::OP_ZERO: begin
                ins_data = 32'h0;
                ins_n    = 3'd4 - {1'b0, r_acc_cnt};
            end
            sha1mh_pkg::OP_LEN_HI: begin
                ins_data = r_len[63:32];
                ins_n    = 3'd4;
            end
            sha1mh_pkg::OP_LEN_LO: begin
                ins_data = r_len[31:0];
                ins_n    = 3'd4;
            end
            default: begin
                ins_data = 32'h0;
                ins_n    = 3'd0;
            end
        endcase
    end

    always_comb begin
        case (ins_n)
            3'd0:    ins_mask = 32'h0000_0000;
            3'd1:    ins_mask = 32'hFF00_0000;
            3'd2:    ins_mask = 32'hFFFF_0000;
            3'd3:    ins_mask = 32'hFFFF_FF00;
            default: ins_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Keep only the bytes actually held in the partial word
    always_comb begin
        case (r_acc_cnt)
            2'd0:    acc_keep = 32'h0000_0000;
            2'd1:    acc_keep = 32'hFF00_0000;
            2'd2:    acc_keep = 32'hFFFF_0000;
            default: acc_keep = 32'hFFFF_FF00;
        endcase
    end

    // Append new bytes behind the held partial word
    assign cat   = {r_acc & acc_keep, 32'h0} |
                   ({ins_data & ins_mask, 32'h0} >> {r_acc_cnt, 3'b000});
    assign total = {1'b0, r_acc_cnt} + ins_n;
    assign push  = total[2];

    assign o_stat.blk_full   = push && (r_wcnt == 4'd15);
    assign o_stat.acc_empty  = (r_acc_cnt == 2'd0);
    assign o_stat.at_len     = (r_wcnt == 4'd14);
    assign o_stat.round_done = (r_round == 7'd79);

    // Round unit
    assign xa = r_work[0];
    assign xb = r_work[1];
    assign xc = r_work[2];
    assign xd = r_work[3];
    assign xe = r_work[4];

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (xb & xc) | (~xb & xd);
            k_val = sha1mh_pkg::K_CH;
        end else if (r_round < 7'd40) begin
            f_val = xb ^ xc ^ xd;
            k_val = sha1mh_pkg::K_P1;
        end else if (r_round < 7'd60) begin
            f_val = (xb & xc) | (xb & xd) | (xc & xd);
            k_val = sha1mh_pkg::K_MAJ;
        end else begin
            f_val = xb ^ xc ^ xd;
            k_val = sha1mh_pkg::K_P2;
        end
    end

    assign t_val = {xa[26:0], xa[31:27]} + f_val + xe + k_val + r_buf[0];

    logic [31:0] sched_x;
    assign sched_x = r_buf[13] ^ r_buf[8] ^ r_buf[2] ^ r_buf[0];
    assign sched   = {sched_x[30:0], sched_x[31]};

    always_comb begin
        case (i_cmd.out_idx)
            3'd0:    o_digest_word = r_chain[0];
            3'd1:    o_digest_word = r_chain[1];
            3'd2:    o_digest_word = r_chain[2];
            3'd3:    o_digest_word = r_chain[3];
            default: o_digest_word = r_chain[4];
        endcase
    end

    // Buffer and partial word: payload, no reset
    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            sha1mh_pkg::OP_ABSORB, sha1mh_pkg::OP_PAD, sha1mh_pkg::OP_ZERO,
            sha1mh_pkg::OP_LEN_HI, sha1mh_pkg::OP_LEN_LO: begin
                if (push) begin
                    r_acc <= cat[31:0];
                    for (int j = 0; j < 15; j++) begin
                        r_buf[j] <= r_buf[j+1];
                    end
                    r_buf[15] <= cat[63:32];
                end else begin
                    r_acc <= cat[63:32];
                end
            end
            sha1mh_pkg::OP_ROUND: begin
                for (int j = 0; j < 15; j++) begin
                    r_buf[j] <= r_buf[j+1];
                end
                r_buf[15] <= sched;
            end
            default: begin
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt <= 2'd0;
            r_wcnt    <= 4'd0;
            r_len     <= 64'd0;
            r_round   <= 7'd0;
            for (int i = 0; i < sha1mh_pkg::NUM_DIGEST; i++) begin
                r_chain[i] <= sha1mh_pkg::IV[i];
                r_work[i]  <= sha1mh_pkg::IV[i];
            end
        end else begin
            case (i_cmd.op) inside
                sha1mh_pkg::OP_ABSORB, sha1mh_pkg::OP_PAD, sha1mh_pkg::OP_ZERO,
                sha1mh_pkg::OP_LEN_HI, sha1mh_pkg::OP_LEN_LO: begin
                    r_acc_cnt <= total[1:0];
                    if (push) begin
                        r_wcnt <= r_wcnt + 4'd1;
                    end
                    if (i_cmd.op == sha1mh_pkg::OP_ABSORB) begin
                        r_len <= r_len + {58'd0, ins_n, 3'b000};
                    end
                end
                sha1mh_pkg::OP_ROUND: begin
                    r_work[0] <= t_val;
                    r_work[1] <= xa;
                    r_work[2] <= {xb[1:0], xb[31:2]};
                    r_work[3] <= xc;
                    r_work[4] <= xd;
                    r_round   <= o_stat.round_done ? 7'd0 : r_round + 7'd1;
                end
                sha1mh_pkg::OP_ADD: begin
                    for (int i = 0; i < sha1mh_pkg::NUM_DIGEST; i++) begin
                        r_chain[i] <= r_chain[i] + r_work[i];
                        r_work[i]  <= r_chain[i] + r_work[i];
                    end
                end
                sha1mh_pkg::OP_CLEAR: begin
                    r_acc_cnt <= 2'd0;
                    r_wcnt    <= 4'd0;
                    r_len     <= 64'd0;
                    for (int i = 0; i < sha1mh_pkg::NUM_DIGEST; i++) begin
                        r_chain[i] <= sha1mh_pkg::IV[i];
                        r_work[i]  <= sha1mh_pkg::IV[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/sha1mh_ctrl.sv
// ----------------------------------------------------------------------------
// sha1mh_ctrl
// Sequencer of the SHA-1 message hasher: absorb, compression rounds,
// padding steps and digest output.
// ----------------------------------------------------------------------------
module sha1mh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_word_index,
    output logic              o_digest_end,
    input  sha1mh_pkg::t_stat i_stat,
    output sha1mh_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret,   n_ret;
    logic [2:0] r_idx,   n_idx;
    sha1mh_pkg::t_op op;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        op      = sha1mh_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op = sha1mh_pkg::OP_ABSORB;
                    if (i_stat.blk_full) begin
                        n_ret   = i_last ? S_PAD : S_IDLE;
                        n_state = S_ROUND;
                    end else begin
                        n_state = i_last ? S_PAD : S_IDLE;
                    end
                end
            end
            S_PAD: begin
                op = sha1mh_pkg::OP_PAD;
                if (i_stat.blk_full) begin
                    n_ret   = S_ZERO;
                    n_state = S_ROUND;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (i_stat.at_len && i_stat.acc_empty) begin
                    n_state = S_LEN_HI;
                end else begin
                    op = sha1mh_pkg::OP_ZERO;
                    if (i_stat.blk_full) begin
                        n_ret   = S_ZERO;
                        n_state = S_ROUND;
                    end
                end
            end
            S_LEN_HI: begin
                op      = sha1mh_pkg::OP_LEN_HI;
                n_state = S_LEN_LO;
            end
            S_LEN_LO: begin
                op      = sha1mh_pkg::OP_LEN_LO;
                n_ret   = S_OUT;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                op = sha1mh_pkg::OP_ROUND;
                if (i_stat.round_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                op      = sha1mh_pkg::OP_ADD;
                n_state = r_ret;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_idx == sha1mh_pkg::LAST_IDX) begin
                        op      = sha1mh_pkg::OP_CLEAR;
                        n_idx   = 3'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
        end
    end

    assign o_cmd.op      = op;
    assign o_cmd.out_idx = r_idx;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_word_index  = r_idx;
    assign o_digest_end  = (r_idx == sha1mh_pkg::LAST_IDX);

endmodule

>>> rtl/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// sha1_message_hasher
// SHA-1 digest over a byte message streamed as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Feed the message as words with a count of valid leading bytes (counts above
// four count as four; short or empty words may come anywhere and the bytes
// simply pack on); mark the final word with last. A word is taken whenever
// no compression or padding step runs; every completed sixteen-word block
// triggers a compression (80 rounds through one shared round unit, then the
// chaining add). After the last word the block appends the 0x80 byte, zero
// fill (up to sixteen buffer words, one a cycle outside a compression, then
// a step that inserts nothing to turn to the length) and the two length
// words, runs one or two compressions, and then offers the five digest words,
// most significant first, each held until it is taken. No new message word
// is taken from the last word until the fifth digest word has gone; the hash
// state then returns to the initial words.
// ----------------------------------------------------------------------------
module sha1_message_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1mh_msg_if.sink    i_msg,
    sha1mh_dig_if.source  o_dig
);

    sha1mh_pkg::t_cmd  cmd;
    sha1mh_pkg::t_stat stat;

    // Sequencer: decides what the datapath does each cycle
    sha1mh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_msg.valid),
        .i_last       (i_msg.last),
        .o_in_ready   (i_msg.ready),
        .o_out_valid  (o_dig.valid),
        .i_out_ready  (o_dig.ready),
        .o_word_index (o_dig.word_index),
        .o_digest_end (o_dig.digest_end),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // Datapath: packing, schedule, rounds, chaining and length
    sha1mh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_msg.data_word),
        .i_bytes_valid (i_msg.bytes_valid),
        .o_stat        (stat),
        .o_digest_word (o_dig.digest_word)
    );

endmodule

>>> rtl/sha1mh_checker.sv
// ----------------------------------------------------------------------------
// sha1mh_checker
// Port-level checks of the SHA-1 message hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1mh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_word_index,
    input logic        i_digest_end
);

    // No message word taken while a digest is on offer
    a_no_input_during_digest: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready
    ) else $error("message word taken while digest pending");

    // End flag marks the fifth word
    a_end_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_digest_end == (i_word_index == sha1mh_pkg::LAST_IDX))
    ) else $error("digest_end does not match word_index");

    // Digest words follow one another in order
    a_index_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_digest_end)
        |=> (i_out_valid && (i_word_index == $past(i_word_index) + 3'd1))
    ) else $error("digest word sequence broken");

    // Stalled digest word holds
    a_stall_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_digest_word) && $stable(i_word_index))
    ) else $error("stalled digest word changed");

endmodule

bind sha1_message_hasher sha1mh_checker u_sha1mh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_msg.ready),
    .i_out_valid   (o_dig.valid),
    .i_out_ready   (o_dig.ready),
    .i_digest_word (o_dig.digest_word),
    .i_word_index  (o_dig.word_index),
    .i_digest_end  (o_dig.digest_end)
);
